/* design/queue_priority_zone_arbiter_assert.svh */
// Assertion macros for the queue priority zone arbiter.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef QUEUE_PRIORITY_ZONE_ARBITER_ASSERT_SVH
`define QUEUE_PRIORITY_ZONE_ARBITER_ASSERT_SVH

// same-cycle implication
`define QPZA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QPZA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/qpza_pkg.sv */
// Shared types, codes and helpers of the queue priority zone arbiter.
// No dependencies.
package qpza_pkg;

	localparam int SIGNALS_DEF      = 16;
	localparam int GROUPS_DEF       = 8;
	localparam int ZONES_DEF        = 8;
	localparam int POLL_ENTRIES_DEF = 8;

	localparam logic [2:0] KIND_LOAD_QUEUE = 3'd0;
	localparam logic [2:0] KIND_LOAD_GROUP = 3'd1;
	localparam logic [2:0] KIND_LOAD_ZONE  = 3'd2;
	localparam logic [2:0] KIND_LOAD_POLL  = 3'd3;
	localparam logic [2:0] KIND_RECOMPUTE  = 3'd4;
	localparam logic [2:0] KIND_QUERY      = 3'd5;

	localparam logic [1:0] CFG_SIGNAL_COUNT     = 2'd0;
	localparam logic [1:0] CFG_ZONE_COUNT       = 2'd1;
	localparam logic [1:0] CFG_POLL_ENTRY_COUNT = 2'd2;

	typedef struct packed {
		logic queue;
		logic grp;
		logic mask;
		logic poll;
	} wen_t;

	function automatic logic in_zone(logic [7:0] mask, logic [7:0] grp);
		return (grp < 8'd8) && mask[grp[2:0]];
	endfunction

endpackage

/* design/queue_priority_zone_arbiter.sv */
// Queue priority zone arbiter top level: request sequencer, status and output register.
// Depends on qpza_pkg, qpza_tables and queue_priority_zone_arbiter_assert.svh.
//
// Input channel in_valid/in_stall carries one request (kind, slot, amount,
// group_mask, cycle_value); output channel out_valid/out_stall returns one
// result per request. Configuration writes use cfg_valid/cfg_ready (always
// ready) with cfg_index and cfg_data; the user must issue them only while no
// request is open, as the block does not enforce it. One request at a time:
// in_stall is high from acceptance until the result is placed in the output
// register. Loads go straight to the output state, queries pass through a
// read state and an evaluate state, and the recompute scans each table one
// entry per cycle through a single registered read port and one comparator.
// A new request is taken while a result still waits; if the receiver stalls,
// the next result waits in the sequencer and in_stall stays high.
// Reset clears the status, the counts and the queue lengths (read as zero);
// groups, zone masks and poll entries hold no value until loaded.
`include "queue_priority_zone_arbiter_assert.svh"

module queue_priority_zone_arbiter #(
	parameter int SIGNALS      = qpza_pkg::SIGNALS_DEF,
	parameter int GROUPS       = qpza_pkg::GROUPS_DEF,
	parameter int ZONES        = qpza_pkg::ZONES_DEF,
	parameter int POLL_ENTRIES = qpza_pkg::POLL_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [3:0]  slot,
	input  logic [15:0] amount,
	input  logic [7:0]  group_mask,
	input  logic [7:0]  cycle_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic [3:0]  top_signal,
	output logic [2:0]  active_zone,
	output logic [15:0] longest_queue,
	output logic [7:0]  cycle_length_out,
	output logic        priority_ready
);

	localparam int SIW  = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;
	localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int ZIW  = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int PIW  = (POLL_ENTRIES > 1) ? $clog2(POLL_ENTRIES) : 1;
	localparam int MAXD0 = (SIGNALS > ZONES) ? SIGNALS : ZONES;
	localparam int MAXD  = (MAXD0 > POLL_ENTRIES) ? MAXD0 : POLL_ENTRIES;
	localparam int CNTW  = $clog2(MAXD + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_QSCAN = 3'd1;
	localparam logic [2:0] ST_GRD   = 3'd2;
	localparam logic [2:0] ST_ZSCAN = 3'd3;
	localparam logic [2:0] ST_PSCAN = 3'd4;
	localparam logic [2:0] ST_QRD   = 3'd5;
	localparam logic [2:0] ST_QEVAL = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]      state_q;
	logic [4:0]      sig_cnt_q;
	logic [3:0]      zone_cnt_q;
	logic [3:0]      poll_cnt_q;
	logic [2:0]      kind_q;
	logic [3:0]      slot_q;
	logic [CNTW-1:0] cnt_q;
	logic            pend_s1;
	logic [CNTW-1:0] idx_s1;
	logic            found_q;
	logic [15:0]     best_q;
	logic [SIW-1:0]  best_i_q;
	logic [SIW-1:0]  top_q;
	logic [ZIW-1:0]  zone_q;
	logic [7:0]      cycle_q;
	logic            ready_q;
	logic [15:0]     max_q;
	logic            grant_q;
	logic            out_valid_q;
	logic            out_granted_q;
	logic [3:0]      out_top_q;
	logic [2:0]      out_zone_q;
	logic [15:0]     out_max_q;
	logic [7:0]      out_cycle_q;
	logic            out_ready_q;

	logic            in_acc;
	logic            out_load;
	logic [CNTW-1:0] n_lim;
	logic [CNTW-1:0] z_lim;
	logic [CNTW-1:0] p_lim;
	logic            issue;
	logic [15:0]     cmp_a;
	logic            cmp_gt;
	logic            cmp_ge;
	logic            slot_sig_ok;
	logic            zone_hit;
	qpza_pkg::wen_t  wen;
	logic [SIW-1:0]  q_raddr;
	logic [SIW-1:0]  grp_raddr;
	logic [ZIW-1:0]  mask_raddr;
	logic [PIW-1:0]  poll_raddr;
	logic [15:0]     q_rdata;
	logic [GW-1:0]   grp_rdata;
	logic [7:0]      mask_rdata;
	logic [15:0]     thr_rdata;
	logic [7:0]      cyc_rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		n_lim = (32'(sig_cnt_q) > SIGNALS) ? CNTW'(SIGNALS) : CNTW'(sig_cnt_q);
		z_lim = (32'(zone_cnt_q) > ZONES) ? CNTW'(ZONES) : CNTW'(zone_cnt_q);
		p_lim = (32'(poll_cnt_q) > POLL_ENTRIES) ? CNTW'(POLL_ENTRIES) : CNTW'(poll_cnt_q);
		issue = ((state_q == ST_QSCAN) && (cnt_q < n_lim)) ||
			((state_q == ST_ZSCAN) && (cnt_q < z_lim)) ||
			((state_q == ST_PSCAN) && (cnt_q < p_lim) && !found_q);
		cmp_a  = (state_q == ST_PSCAN) ? thr_rdata : q_rdata;
		cmp_gt = cmp_a > best_q;
		cmp_ge = cmp_gt || (cmp_a == best_q);
		slot_sig_ok = 32'(slot_q) < SIGNALS;
		zone_hit = qpza_pkg::in_zone(mask_rdata, 8'(grp_rdata));

		wen.queue = in_acc && (kind == qpza_pkg::KIND_LOAD_QUEUE) && (32'(slot) < SIGNALS);
		wen.grp   = in_acc && (kind == qpza_pkg::KIND_LOAD_GROUP) && (32'(slot) < SIGNALS)
			&& (32'(amount) < GROUPS);
		wen.mask  = in_acc && (kind == qpza_pkg::KIND_LOAD_ZONE) && (32'(slot) < ZONES);
		wen.poll  = in_acc && (kind == qpza_pkg::KIND_LOAD_POLL) && (32'(slot) < POLL_ENTRIES);

		q_raddr    = SIW'(cnt_q);
		grp_raddr  = (kind_q == qpza_pkg::KIND_QUERY) ? SIW'(slot_q) : best_i_q;
		mask_raddr = (state_q == ST_QRD) ? zone_q : ZIW'(cnt_q);
		poll_raddr = PIW'(cnt_q);
	end

	qpza_tables #(
		.SIGNALS      (SIGNALS),
		.GROUPS       (GROUPS),
		.ZONES        (ZONES),
		.POLL_ENTRIES (POLL_ENTRIES)
	) u_tables (
		.clk        (clk),
		.arst_n     (arst_n),
		.wen        (wen),
		.wr_slot    (slot),
		.wr_amount  (amount),
		.wr_mask    (group_mask),
		.wr_cycle   (cycle_value),
		.q_raddr    (q_raddr),
		.grp_raddr  (grp_raddr),
		.mask_raddr (mask_raddr),
		.poll_raddr (poll_raddr),
		.q_rdata    (q_rdata),
		.grp_rdata  (grp_rdata),
		.mask_rdata (mask_rdata),
		.thr_rdata  (thr_rdata),
		.cyc_rdata  (cyc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_cnt_q  <= '0;
			zone_cnt_q <= '0;
			poll_cnt_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qpza_pkg::CFG_SIGNAL_COUNT:     sig_cnt_q  <= cfg_data;
				qpza_pkg::CFG_ZONE_COUNT:       zone_cnt_q <= cfg_data[3:0];
				qpza_pkg::CFG_POLL_ENTRY_COUNT: poll_cnt_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			kind_q        <= '0;
			slot_q        <= '0;
			cnt_q         <= '0;
			pend_s1       <= 1'b0;
			idx_s1        <= '0;
			found_q       <= 1'b0;
			best_q        <= '0;
			best_i_q      <= '0;
			top_q         <= '0;
			zone_q        <= '0;
			cycle_q       <= '0;
			ready_q       <= 1'b0;
			max_q         <= '0;
			grant_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			out_granted_q <= 1'b0;
			out_top_q     <= '0;
			out_zone_q    <= '0;
			out_max_q     <= '0;
			out_cycle_q   <= '0;
			out_ready_q   <= 1'b0;
		end else begin
			pend_s1 <= issue;
			idx_s1  <= cnt_q;
			if (issue)
				cnt_q <= cnt_q + CNTW'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						kind_q  <= kind;
						slot_q  <= slot;
						cnt_q   <= '0;
						found_q <= 1'b0;
						best_q  <= '0;
						grant_q <= 1'b0;
						unique case (kind)
							qpza_pkg::KIND_RECOMPUTE: state_q <= ST_QSCAN;
							qpza_pkg::KIND_QUERY:     state_q <= ST_QRD;
							default:                  state_q <= ST_OUT;
						endcase
					end
				end
				ST_QSCAN: begin
					if (pend_s1 && ((idx_s1 == '0) || cmp_gt)) begin
						best_q   <= q_rdata;
						best_i_q <= SIW'(idx_s1);
					end
					if (!pend_s1 && (cnt_q == n_lim)) begin
						max_q <= best_q;
						cnt_q <= '0;
						if (n_lim != '0) begin
							ready_q <= 1'b1;
							top_q   <= best_i_q;
							state_q <= ST_GRD;
						end else begin
							ready_q <= 1'b0;
							state_q <= ST_PSCAN;
						end
					end
				end
				ST_GRD: begin
					state_q <= ST_ZSCAN;
				end
				ST_ZSCAN: begin
					if (pend_s1 && zone_hit)
						zone_q <= ZIW'(idx_s1);
					if (!pend_s1 && (cnt_q == z_lim)) begin
						cnt_q   <= '0;
						state_q <= ST_PSCAN;
					end
				end
				ST_PSCAN: begin
					if (pend_s1 && !found_q && cmp_ge) begin
						cycle_q <= cyc_rdata;
						found_q <= 1'b1;
					end
					if (!pend_s1 && ((cnt_q == p_lim) || found_q))
						state_q <= ST_OUT;
				end
				ST_QRD: begin
					state_q <= ST_QEVAL;
				end
				ST_QEVAL: begin
					grant_q <= ready_q && slot_sig_ok && (CNTW'(zone_q) < z_lim) && zone_hit;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						out_granted_q <= grant_q;
						out_top_q     <= 4'(top_q);
						out_zone_q    <= 3'(zone_q);
						out_max_q     <= max_q;
						out_cycle_q   <= cycle_q;
						out_ready_q   <= ready_q;
						state_q       <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign granted          = out_granted_q;
	assign top_signal       = out_top_q;
	assign active_zone      = out_zone_q;
	assign longest_queue    = out_max_q;
	assign cycle_length_out = out_cycle_q;
	assign priority_ready   = out_ready_q;

	`QPZA_ASSERT_NEXT(a_accept_busy, in_acc, state_q != ST_IDLE,
		"accepted request did not leave idle")
	`QPZA_ASSERT_NOW(a_out_from_seq, $rose(out_valid_q), $past(state_q) == ST_OUT,
		"result raised outside output state")
	`QPZA_ASSERT_NOW(a_not_ready_zero, !ready_q, max_q == '0,
		"longest queue nonzero without a covering recompute")
	`QPZA_ASSERT_NOW(a_pend_in_scan, pend_s1,
		(state_q == ST_QSCAN) || (state_q == ST_ZSCAN) || (state_q == ST_PSCAN),
		"pending table read outside a scan")

endmodule

/* design/qpza_tables.sv */
// Table storage: queue lengths, signal groups, zone masks and poll entries.
// Registered read ports; queue lengths read as zero until written.
// Depends on qpza_pkg.
module qpza_tables #(
	parameter int SIGNALS      = qpza_pkg::SIGNALS_DEF,
	parameter int GROUPS       = qpza_pkg::GROUPS_DEF,
	parameter int ZONES        = qpza_pkg::ZONES_DEF,
	parameter int POLL_ENTRIES = qpza_pkg::POLL_ENTRIES_DEF,
	localparam int SIW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1,
	localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1,
	localparam int ZIW = (ZONES > 1) ? $clog2(ZONES) : 1,
	localparam int PIW = (POLL_ENTRIES > 1) ? $clog2(POLL_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qpza_pkg::wen_t    wen,
	input  logic [3:0]        wr_slot,
	input  logic [15:0]       wr_amount,
	input  logic [7:0]        wr_mask,
	input  logic [7:0]        wr_cycle,
	input  logic [SIW-1:0]    q_raddr,
	input  logic [SIW-1:0]    grp_raddr,
	input  logic [ZIW-1:0]    mask_raddr,
	input  logic [PIW-1:0]    poll_raddr,
	output logic [15:0]       q_rdata,
	output logic [GW-1:0]     grp_rdata,
	output logic [7:0]        mask_rdata,
	output logic [15:0]       thr_rdata,
	output logic [7:0]        cyc_rdata
);

	logic [15:0]       queue_mem [SIGNALS];
	logic [GW-1:0]     group_mem [SIGNALS];
	logic [7:0]        mask_mem  [ZONES];
	logic [15:0]       thr_mem   [POLL_ENTRIES];
	logic [7:0]        cyc_mem   [POLL_ENTRIES];
	logic [SIGNALS-1:0] qvalid_q;
	logic              qv_rd_q;
	logic [15:0]       q_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qvalid_q <= '0;
			qv_rd_q  <= 1'b0;
		end else begin
			qv_rd_q <= qvalid_q[q_raddr];
			if (wen.queue)
				qvalid_q[SIW'(wr_slot)] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wen.queue)
			queue_mem[SIW'(wr_slot)] <= wr_amount;
		if (wen.grp)
			group_mem[SIW'(wr_slot)] <= GW'(wr_amount);
		if (wen.mask)
			mask_mem[ZIW'(wr_slot)] <= wr_mask;
		if (wen.poll) begin
			thr_mem[PIW'(wr_slot)] <= wr_amount;
			cyc_mem[PIW'(wr_slot)] <= wr_cycle;
		end
		q_rd_q     <= queue_mem[q_raddr];
		grp_rdata  <= group_mem[grp_raddr];
		mask_rdata <= mask_mem[mask_raddr];
		thr_rdata  <= thr_mem[poll_raddr];
		cyc_rdata  <= cyc_mem[poll_raddr];
	end

	assign q_rdata = qv_rd_q ? q_rd_q : 16'd0;

endmodule
